[hw/rtl/uer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TICK_COUNTER_BITS = 16;
    localparam int TIMEOUT_BITS      = 16;
    localparam int CM_BITS           = 16;
    localparam int FRAC_BITS         = 8;
    // compare width for the tick counter against the timeout setting
    localparam int CMP_BITS = (TICK_COUNTER_BITS > TIMEOUT_BITS) ?
                              TICK_COUNTER_BITS : TIMEOUT_BITS;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(25000);
    localparam logic [FRAC_BITS-1:0]    TPC_RESET     = FRAC_BITS'(58);
    localparam logic [CM_BITS-1:0]      CM_MAX        = {CM_BITS{1'b1}};
    localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = {TICK_COUNTER_BITS{1'b1}};
    localparam logic [TICK_COUNTER_BITS-1:0] TRIG_LOW_TICKS  = TICK_COUNTER_BITS'(4);
    localparam logic [TICK_COUNTER_BITS-1:0] TRIG_HIGH_TICKS = TICK_COUNTER_BITS'(10);

    // configuration register indexes
    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_TICKS_PER_CM  = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LOW  = 5'b00010,
        PH_HIGH = 5'b00100,
        PH_RISE = 5'b01000,
        PH_MEAS = 5'b10000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo;
    } sample_t;

    typedef struct packed {
        logic               trigger;
        logic               done_res;
        logic               timed_out;
        logic [CM_BITS-1:0] distance_cm;
        logic               busy_res;
    } result_t;

endpackage

[hw/rtl/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger pulse sequencer and echo width measurement, one word per tick.
// ----------------------------------------------------------------------------
// each result word is registered into the output word, or into the skid entry while stalled
// throughput: one sample word per cycle while sample_stall is low, as the phase updates on each taken word
// a two-entry output buffer takes one more word while a result is stalled
// reset: phase idle, counters zero, timeout 25000 ticks, 58 ticks per cm
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  uer_pkg::sample_t   sample,
    output logic               result_valid,
    input  logic               result_stall,
    output uer_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    uer_pkg::phase_t                                  phase_reg, phase_next;
    logic [uer_pkg::TICK_COUNTER_BITS-1:0]            ticks_reg, ticks_next;
    logic [uer_pkg::FRAC_BITS-1:0]                    frac_reg, frac_next;
    logic [uer_pkg::CM_BITS-1:0]                      cm_reg, cm_next;
    logic [uer_pkg::TIMEOUT_BITS-1:0]                 timeout_reg;
    logic [uer_pkg::FRAC_BITS-1:0]                    tpc_reg;

    uer_pkg::result_t res;
    uer_pkg::result_t main_reg, skid_reg;
    logic             main_valid_reg, skid_valid_reg;

    logic accept;
    logic pop;
    logic limit_hit;
    logic [uer_pkg::FRAC_BITS-1:0] div_frac_in, frac_inc;
    logic [uer_pkg::CM_BITS-1:0]   div_cm_in;
    logic [uer_pkg::FRAC_BITS-1:0] div_frac_out;
    logic [uer_pkg::CM_BITS-1:0]   div_cm_out;

    assign cfg_ready    = 1'b1;
    assign sample_stall = skid_valid_reg;
    assign accept       = sample_valid && !skid_valid_reg;
    assign pop          = main_valid_reg && !result_stall;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= uer_pkg::TIMEOUT_RESET;
            tpc_reg     <= uer_pkg::TPC_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                uer_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                uer_pkg::CFG_TICKS_PER_CM:  tpc_reg <= cfg_data[uer_pkg::FRAC_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign limit_hit =
        (uer_pkg::CMP_BITS'(ticks_reg) >= uer_pkg::CMP_BITS'(timeout_reg)) ||
        (ticks_reg == uer_pkg::TICK_MAX);

    // one step of the incremental division; the rise tick starts from zero
    assign div_frac_in = (phase_reg == uer_pkg::PH_RISE) ? '0 : frac_reg;
    assign div_cm_in   = (phase_reg == uer_pkg::PH_RISE) ? '0 : cm_reg;
    assign frac_inc    = div_frac_in + uer_pkg::FRAC_BITS'(1);

    always_comb
    begin
        if (frac_inc == tpc_reg)
        begin
            div_frac_out = '0;
            div_cm_out   = (div_cm_in == uer_pkg::CM_MAX) ? div_cm_in :
                           div_cm_in + uer_pkg::CM_BITS'(1);
        end
        else
        begin
            div_frac_out = frac_inc;
            div_cm_out   = div_cm_in;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        frac_next       = frac_reg;
        cm_next         = cm_reg;
        res.trigger     = 1'b0;
        res.done_res    = 1'b0;
        res.timed_out   = 1'b0;
        res.distance_cm = '0;
        res.busy_res    = 1'b1;
        case (phase_reg)
            uer_pkg::PH_LOW:
            begin
                if (ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1) >= uer_pkg::TRIG_LOW_TICKS)
                begin
                    phase_next = uer_pkg::PH_HIGH;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1);
                end
            end
            uer_pkg::PH_HIGH:
            begin
                res.trigger = 1'b1;
                if (ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1) >= uer_pkg::TRIG_HIGH_TICKS)
                begin
                    phase_next = uer_pkg::PH_RISE;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1);
                end
            end
            uer_pkg::PH_RISE:
            begin
                if (sample.echo)
                begin
                    phase_next = uer_pkg::PH_MEAS;
                    ticks_next = uer_pkg::TICK_COUNTER_BITS'(1);
                    frac_next  = div_frac_out;
                    cm_next    = div_cm_out;
                end
                else if (limit_hit)
                begin
                    res.done_res  = 1'b1;
                    res.timed_out = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1);
                end
            end
            uer_pkg::PH_MEAS:
            begin
                if (!sample.echo)
                begin
                    res.done_res    = 1'b1;
                    res.distance_cm = cm_reg;
                end
                else if (limit_hit)
                begin
                    res.done_res  = 1'b1;
                    res.timed_out = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_reg + uer_pkg::TICK_COUNTER_BITS'(1);
                    frac_next  = div_frac_out;
                    cm_next    = div_cm_out;
                end
            end
            default:
            begin
                // idle, and any unused code behaves as idle
                phase_next = uer_pkg::PH_IDLE;
                if (sample.start_req)
                begin
                    phase_next = uer_pkg::PH_LOW;
                    ticks_next = uer_pkg::TICK_COUNTER_BITS'(1);
                end
                else
                begin
                    res.busy_res = 1'b0;
                end
            end
        endcase
        if (res.done_res)
        begin
            res.busy_res = 1'b0;
            phase_next   = uer_pkg::PH_IDLE;
            ticks_next   = '0;
            frac_next    = '0;
            cm_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            ticks_reg <= '0;
            frac_reg  <= '0;
            cm_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            frac_reg  <= frac_next;
            cm_reg    <= cm_next;
        end
    end

    // output word plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            main_valid_reg <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

endmodule

[tb/ultrasonic_echo_ranger_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test
// Checks the ranger tick by tick against a behavioral model of the trigger
// pulse, echo wait and width measurement. The run covers directed corner
// cases, including zero timeout, the wrapping cm divisor and one tick per cm
// with words back to back. It then runs randomized measurement sequences
// with noise under several settings, with random stalls on both sides of
// the block.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BUDGET   = 80;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    uer_pkg::sample_t    sample       = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    uer_pkg::result_t    result;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic                cfg_index    = uer_pkg::CFG_TIMEOUT_TICKS;
    logic [15:0]         cfg_data     = '0;

    // behavioral copy of the ranger state and settings
    uer_pkg::phase_t                        model_phase   = uer_pkg::PH_IDLE;
    logic [uer_pkg::TICK_COUNTER_BITS-1:0]  model_ticks   = '0;
    logic [uer_pkg::FRAC_BITS-1:0]          cm_frac       = '0;
    logic [uer_pkg::CM_BITS-1:0]            cm_total      = '0;
    logic [uer_pkg::TIMEOUT_BITS-1:0]       model_timeout = uer_pkg::TIMEOUT_RESET;
    logic [uer_pkg::FRAC_BITS-1:0]          model_tpc     = uer_pkg::TPC_RESET;

    uer_pkg::sample_t sample_queue[$];
    uer_pkg::result_t expected_results[$];

    int  queued_count   = 0;
    int  mismatch_count = 0;
    int  idle_left      = 0;
    int  stall_left     = 0;
    int  hold_asks      = 0;
    int  hold_granted   = 0;
    int  quiet_cycles   = 0;
    bit  steady_flow    = 1'b0;

    ultrasonic_echo_ranger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit wait_expired();
        return (model_ticks >= model_timeout) || (model_ticks == uer_pkg::TICK_MAX);
    endfunction

    function automatic void divide_tick();
        logic [uer_pkg::FRAC_BITS-1:0] next_frac;
        next_frac = cm_frac + 1'b1;
        if (next_frac == model_tpc)
        begin
            cm_frac = '0;
            if (cm_total != uer_pkg::CM_MAX)
                cm_total = cm_total + 1'b1;
        end
        else
            cm_frac = next_frac;
    endfunction

    function automatic uer_pkg::result_t advance_ranger(input uer_pkg::sample_t s);
        uer_pkg::result_t r;
        bit               finished;
        r          = '0;
        r.busy_res = 1'b1;
        finished   = 1'b0;
        case (model_phase)
            uer_pkg::PH_LOW:
            begin
                model_ticks = model_ticks + 1'b1;
                if (model_ticks >= uer_pkg::TRIG_LOW_TICKS)
                begin
                    model_phase = uer_pkg::PH_HIGH;
                    model_ticks = '0;
                end
            end
            uer_pkg::PH_HIGH:
            begin
                r.trigger   = 1'b1;
                model_ticks = model_ticks + 1'b1;
                if (model_ticks >= uer_pkg::TRIG_HIGH_TICKS)
                begin
                    model_phase = uer_pkg::PH_RISE;
                    model_ticks = '0;
                end
            end
            uer_pkg::PH_RISE:
            begin
                if (s.echo)
                begin
                    model_phase = uer_pkg::PH_MEAS;
                    model_ticks = uer_pkg::TICK_COUNTER_BITS'(1);
                    cm_frac     = '0;
                    cm_total    = '0;
                    divide_tick();
                end
                else if (wait_expired())
                begin
                    finished    = 1'b1;
                    r.timed_out = 1'b1;
                end
                else
                    model_ticks = model_ticks + 1'b1;
            end
            uer_pkg::PH_MEAS:
            begin
                if (!s.echo)
                begin
                    finished      = 1'b1;
                    r.distance_cm = cm_total;
                end
                else if (wait_expired())
                begin
                    finished    = 1'b1;
                    r.timed_out = 1'b1;
                end
                else
                begin
                    model_ticks = model_ticks + 1'b1;
                    divide_tick();
                end
            end
            default:
            begin
                model_phase = uer_pkg::PH_IDLE;
                if (s.start_req)
                begin
                    model_phase = uer_pkg::PH_LOW;
                    model_ticks = uer_pkg::TICK_COUNTER_BITS'(1);
                end
                else
                    r.busy_res = 1'b0;
            end
        endcase
        if (finished)
        begin
            r.done_res  = 1'b1;
            r.busy_res  = 1'b0;
            model_phase = uer_pkg::PH_IDLE;
            model_ticks = '0;
            cm_frac     = '0;
            cm_total    = '0;
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 120);
    endfunction

    // sender: offers the queued words, holds a stalled word unchanged
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                expected_results.push_back(advance_ranger(sample));
            if (!(sample_valid && sample_stall))
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    sample_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    sample_valid <= 1'b1;
                    sample       <= sample_queue.pop_front();
                    if (steady_flow || $urandom_range(0, 99) < 55)
                        idle_left = 0;
                    else
                        idle_left = pick_gap();
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_asks != hold_granted)
        begin
            hold_granted = hold_asks;
            stall_left   = LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!steady_flow && $urandom_range(0, 99) < 15)
        begin
            stall_left = pick_gap() - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        uer_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("trigger", int'(want.trigger), int'(result.trigger));
                check_field("done_res", int'(want.done_res), int'(result.done_res));
                check_field("timed_out", int'(want.timed_out), int'(result.timed_out));
                check_field("distance_cm", int'(want.distance_cm),
                            int'(result.distance_cm));
                check_field("busy_res", int'(want.busy_res), int'(result.busy_res));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ultrasonic_echo_ranger verification failed");
                $finish;
            end
        end
    end

    task automatic push_tick(input logic start_bit, input logic echo_bit);
        uer_pkg::sample_t s;
        s.start_req = start_bit;
        s.echo      = echo_bit;
        sample_queue.push_back(s);
        queued_count++;
    endtask

    task automatic queue_idle(input int n);
        repeat (n) push_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // random words, starts now and then, echo unrelated to the trigger
    task automatic queue_noise(input int n);
        repeat (n) push_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    endtask

    // one well-formed measurement, cut short where the current timeout ends it
    task automatic queue_measurement(input int rise_delay, input int high_width);
        int limit;
        int limit_hi;
        limit    = int'(model_timeout);
        limit_hi = (limit < 1) ? 1 : limit;
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (13) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (rise_delay > limit)
        begin
            repeat (limit + 1) push_tick(1'($urandom_range(0, 1)), 1'b0);
            return;
        end
        repeat (rise_delay) push_tick(1'($urandom_range(0, 1)), 1'b0);
        if (high_width > limit_hi)
        begin
            repeat (limit_hi + 1) push_tick(1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        repeat (high_width) push_tick(1'($urandom_range(0, 1)), 1'b1);
        push_tick(1'($urandom_range(0, 1)), 1'b0);
    endtask

    function automatic int pick_span(input int limit);
        int cap;
        cap = (limit < 40) ? limit : 40;
        if (limit > 700)
            return $urandom_range(0, cap);
        case ($urandom_range(0, 9))
            0: return limit;
            1: return limit + 1;
            2: return limit + $urandom_range(2, 20);
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    task automatic wait_drained();
        while (sample_queue.size() != 0 || sample_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // both registers back to back, valid kept high between them
    task automatic write_settings(input logic [15:0] timeout, input logic [7:0] tpc);
        logic [7:0] pad;
        pad = 8'($urandom_range(0, 255));
        cfg_valid <= 1'b1;
        cfg_index <= uer_pkg::CFG_TIMEOUT_TICKS;
        cfg_data  <= timeout;
        do @(posedge clk); while (!cfg_ready);
        model_timeout = timeout;
        cfg_index <= uer_pkg::CFG_TICKS_PER_CM;
        cfg_data  <= {pad, tpc};
        do @(posedge clk); while (!cfg_ready);
        model_tpc = tpc;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int              phase_start;
        int              width;
        logic [15:0]     timeout;
        logic [7:0]      tpc;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle words, then a short echo with starts while busy
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        queue_measurement(2, 3);
        queue_idle(2);
        wait_drained();

        // zero timeout: rise wait gives up at once, width one still measures
        write_settings(16'd0, 8'd1);
        queue_measurement(5, 1);
        queue_measurement(0, 1);
        queue_measurement(0, 2);
        wait_drained();

        // divisor of zero counts as 256
        write_settings(16'd300, 8'd0);
        queue_measurement(1, 256);
        wait_drained();

        // one tick per cm with words back to back
        steady_flow = 1'b1;
        write_settings(16'd65535, 8'd1);
        queue_measurement(0, 60);
        queue_measurement(3, 2);
        wait_drained();
        steady_flow = 1'b0;

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0:
                begin
                    timeout = 16'd12;
                    tpc     = 8'd3;
                end
                1:
                begin
                    timeout = 16'd0;
                    tpc     = 8'd1;
                end
                2:
                begin
                    timeout = 16'd1;
                    tpc     = 8'd255;
                end
                3:
                begin
                    timeout = 16'd600;
                    tpc     = 8'd0;
                end
                4:
                begin
                    timeout = 16'd65535;
                    tpc     = 8'd255;
                end
                5:
                begin
                    timeout = 16'd40;
                    tpc     = 8'd2;
                end
                default:
                begin
                    timeout = 16'($urandom_range(2, 60));
                    tpc     = 8'($urandom_range(1, 254));
                end
            endcase
            write_settings(timeout, tpc);
            steady_flow = (p == 5) || ($urandom_range(0, 3) == 0);
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_BUDGET)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise($urandom_range(3, 40));
                else
                begin
                    width = pick_span(int'(model_timeout));
                    if (width < 1)
                        width = 1;
                    queue_measurement(pick_span(int'(model_timeout)), width);
                    queue_idle($urandom_range(0, 3));
                end
            end
            // back up the result side while words keep coming
            if (p == 2 || p == 6)
                hold_asks++;
            wait_drained();
        end

        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ultrasonic_echo_ranger verification clean");
        else
            $display("ultrasonic_echo_ranger verification failed");
        $finish;
    end

endmodule
